// ----- design/gdhs_pkg.sv -----
package gdhs_pkg;

  localparam int unsigned NormW = 5;
  localparam int unsigned GateW = 13;
  localparam int unsigned MagW  = 14;
  localparam int unsigned ProdW = 24;
  localparam int unsigned ValW  = 25;

  localparam logic [NormW-1:0] NormShiftReset = 5'd12;

  // hard sigmoid constants, Q12 slope and Q24 offsets
  localparam logic signed [31:0] SigLowLimit = -32'sd10240;
  localparam logic signed [31:0] SigHighLimit = 32'sd10240;
  localparam logic [9:0]         SigSlopeQ12 = 10'd819;
  localparam logic [ValW-1:0]    SigHalfQ24  = 25'd8388608;
  localparam logic [ValW-1:0]    SigOneQ24   = 25'd16777216;
  localparam logic [GateW-1:0]   GateMax     = 13'd4096;

  typedef struct packed {
    logic load_in;
    logic mac;
    logic norm;
    logic sig;
    logic out_load;
    logic cfg_we;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// ----- design/gdhs_ctrl.sv -----
module gdhs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  gdhs_pkg::dp_status_t status_i,
  output gdhs_pkg::dp_cmd_t    cmd_o
);
  import gdhs_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMac  = 3'd1;
  localparam logic [2:0] StNorm = 3'd2;
  localparam logic [2:0] StSig  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // output register can take a new value when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.cfg_we   = cfg_valid_i && (state_q == StIdle);
    out_valid_d    = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StMac;
        end
      end
      StMac: begin
        cmd_o.mac = 1'b1;
        state_d   = status_i.last ? StNorm : StIdle;
      end
      StNorm: begin
        cmd_o.norm = 1'b1;
        state_d    = StSig;
      end
      StSig: begin
        cmd_o.sig = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/gdhs_datapath.sv -----
module gdhs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gdhs_pkg::dp_cmd_t           cmd_i,
  output gdhs_pkg::dp_status_t        status_o,
  input  logic [gdhs_pkg::NormW-1:0]  cfg_data_i,
  input  logic                        first_term_i,
  input  logic signed [31:0]          bias_value_i,
  input  logic signed [15:0]          x_value_i,
  input  logic signed [15:0]          x_weight_i,
  input  logic signed [15:0]          h_value_i,
  input  logic signed [15:0]          rec_weight_i,
  input  logic                        last_term_i,
  output logic [gdhs_pkg::GateW-1:0]  gate_value_o
);
  import gdhs_pkg::*;

  logic               first_q, last_q;
  logic signed [31:0] bias_q;
  logic signed [15:0] xv_q, xw_q, hv_q, rw_q;
  logic [31:0]        acc_q, acc_d;
  logic [NormW-1:0]   norm_shift_q;
  logic               pos_q, in_range_q;
  logic [MagW-1:0]    mag_q;
  logic [ValW-1:0]    val_q, val_d;
  logic [GateW-1:0]   gate_q, gate_d;

  logic signed [31:0] xprod, hprod, base;
  logic signed [31:0] sum_sh, sum_neg;
  logic               pos_d, in_range_d;
  logic [MagW-1:0]    mag_d;
  logic [ProdW-1:0]   slope_prod;
  logic [ValW-1:0]    val_sh;

  function automatic logic signed [31:0] x_value_q_ext(input logic signed [15:0] v);
    x_value_q_ext = 32'(v);
  endfunction

  // multiply-accumulate, wraps modulo 2^32
  assign xprod = x_value_q_ext(xv_q) * x_value_q_ext(xw_q);
  assign hprod = x_value_q_ext(hv_q) * x_value_q_ext(rw_q);
  assign base  = first_q ? (bias_q + xprod) : $signed(acc_q);
  assign acc_d = base + hprod;

  // normalize and fold onto the non-negative half of the curve
  assign sum_sh     = $signed(acc_q) >>> norm_shift_q;
  assign sum_neg    = -sum_sh;
  assign pos_d      = (sum_sh > 32'sd0);
  assign in_range_d = pos_d ? (sum_sh <= SigHighLimit) : (sum_sh >= SigLowLimit);
  assign mag_d      = pos_d ? sum_sh[MagW-1:0] : sum_neg[MagW-1:0];

  assign slope_prod = ProdW'(mag_q) * ProdW'(SigSlopeQ12);

  always_comb begin
    if (!in_range_q) begin
      val_d = pos_q ? SigOneQ24 : '0;
    end else if (pos_q) begin
      val_d = SigHalfQ24 + ValW'(slope_prod);
    end else begin
      val_d = SigHalfQ24 - ValW'(slope_prod);
    end
  end

  assign val_sh = val_q >> norm_shift_q;
  assign gate_d = (val_sh > ValW'(GateMax)) ? GateMax : val_sh[GateW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      norm_shift_q <= NormShiftReset;
    end else begin
      if (cmd_i.mac) begin
        acc_q <= acc_d;
      end
      if (cmd_i.cfg_we) begin
        norm_shift_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      first_q <= first_term_i;
      last_q  <= last_term_i;
      bias_q  <= bias_value_i;
      xv_q    <= x_value_i;
      xw_q    <= x_weight_i;
      hv_q    <= h_value_i;
      rw_q    <= rec_weight_i;
    end
    if (cmd_i.norm) begin
      pos_q      <= pos_d;
      in_range_q <= in_range_d;
      mag_q      <= mag_d;
    end
    if (cmd_i.sig) begin
      val_q <= val_d;
    end
    if (cmd_i.out_load) begin
      gate_q <= gate_d;
    end
  end

  assign status_o.last = last_q;
  assign gate_value_o  = gate_q;

endmodule

// ----- design/gru_gate_dot_hard_sigmoid.sv -----
// channel  direction  handshake                fields
// in       input      in_valid_i / in_stall_o  first_term .. last_term
// out      output     out_valid_o / out_stall_i gate_value
// cfg      input      cfg_valid_i / cfg_ready_o norm_shift (cfg_data_i)
//
// an item without last_term goes through capture, then one multiply-accumulate
// an item with last_term goes through capture, accumulate, shift, sigmoid multiply, output
// the single accumulator and the state machine that walks it set these steps
// reset clears the accumulator to zero and norm_shift to 12
// a stalled output holds its value; the next item is taken while it waits
module gru_gate_dot_hard_sigmoid (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       first_term_i,
  input  logic signed [31:0]         bias_value_i,
  input  logic signed [15:0]         x_value_i,
  input  logic signed [15:0]         x_weight_i,
  input  logic signed [15:0]         h_value_i,
  input  logic signed [15:0]         rec_weight_i,
  input  logic                       last_term_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gdhs_pkg::GateW-1:0] gate_value_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [gdhs_pkg::NormW-1:0] cfg_data_i
);
  import gdhs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gdhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gdhs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_data_i   (cfg_data_i),
    .first_term_i (first_term_i),
    .bias_value_i (bias_value_i),
    .x_value_i    (x_value_i),
    .x_weight_i   (x_weight_i),
    .h_value_i    (h_value_i),
    .rec_weight_i (rec_weight_i),
    .last_term_i  (last_term_i),
    .gate_value_o (gate_value_o)
  );

endmodule
